FILE: sv/olist_pkg.sv
// Package for the ordered list engine: sizes, word layouts, command and
// status codes, and the structs passed between the top level and its cells.
// No dependencies.
package olist_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int POS_W    = 8;
    localparam int CMD_W    = 4;
    localparam int ST_W     = 3;
    localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Input word layout: cmd, operand_value, operand_position
    localparam int IN_CMD_LSB = 0;
    localparam int IN_VAL_LSB = IN_CMD_LSB + CMD_W;
    localparam int IN_POS_LSB = IN_VAL_LSB + VAL_W;
    localparam int IN_BITS    = IN_POS_LSB + POS_W;
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;

    // Output word layout: status, found_position, read_value, element_count
    localparam int OUT_ST_LSB  = 0;
    localparam int OUT_FP_LSB  = OUT_ST_LSB + ST_W;
    localparam int OUT_RV_LSB  = OUT_FP_LSB + CNT_W;
    localparam int OUT_CNT_LSB = OUT_RV_LSB + VAL_W;
    localparam int OUT_BITS    = OUT_CNT_LSB + CNT_W;
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 4'd0,
        CMD_INS_REAR  = 4'd1,
        CMD_INS_ORD   = 4'd2,
        CMD_SEARCH    = 4'd3,
        CMD_READ_POS  = 4'd4,
        CMD_DEL_POS   = 4'd5,
        CMD_DEL_KEY   = 4'd6,
        CMD_DEL_FRONT = 4'd7,
        CMD_DEL_REAR  = 4'd8,
        CMD_CLEAR     = 4'd9
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 3'd0,
        ST_BADPOS = 3'd1,
        ST_NOKEY  = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic              ins;    // open a gap at 'at' and write value
        logic              del;    // close the gap at 'at'
        logic [IDX_W-1:0]  at;
        logic [VAL_W-1:0]  value;  // insert value, also the compare key
    } t_cell_ctl;

    // Compare flags from each cell
    typedef struct packed {
        logic eq;   // entry equals key
        logic ge;   // entry >= value, signed
    } t_cell_flags;

endpackage

FILE: sv/olist_cell.sv
// One storage cell of the list chain: holds one entry, compares it with the
// broadcast key and shifts towards either neighbour on insert or delete.
// Depends on olist_pkg.
module olist_cell (
    input  logic                        i_clk,
    input  logic [olist_pkg::IDX_W-1:0] i_index,   // fixed place in the chain
    input  olist_pkg::t_cell_ctl        i_ctl,
    input  logic [olist_pkg::VAL_W-1:0] i_left,    // entry of the cell below
    input  logic [olist_pkg::VAL_W-1:0] i_right,   // entry of the cell above
    output logic [olist_pkg::VAL_W-1:0] o_data,
    output olist_pkg::t_cell_flags      o_flags
);
    import olist_pkg::*;

    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;

    // Local compares against the broadcast operand
    always_comb begin
        o_flags.eq = (r_data == i_ctl.value);
        o_flags.ge = ($signed(r_data) >= $signed(i_ctl.value));
    end

    // Insert moves entries up from the left, delete pulls them down from the right
    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (i_index == i_ctl.at) begin
                n_data = i_ctl.value;
            end else if (i_index > i_ctl.at) begin
                n_data = i_left;
            end
        end else if (i_ctl.del) begin
            if (i_index >= i_ctl.at) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: sv/ordered_list_engine_top.sv
// Ordered list engine top level: a chain of CAPACITY cells plus command
// decode, first-match search, the element count and the result register.
// A result appears on m_tdata, registered, in the cycle after its command is taken.
// Throughput: one command per cycle unless the result word is stalled; every cell
// compares and shifts at once, and the result register frees once its word is taken.
// Reset (i_rst_n low, synchronous) empties the list and drops m_tvalid.
module ordered_list_engine_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // cmd[3:0], operand_value[35:4], operand_position[43:36], zero fill
    input  logic [olist_pkg::IN_W-1:0]   s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // status[2:0], found_position[7:3], read_value[39:8],
    // element_count[44:40], zero fill
    output logic [olist_pkg::OUT_W-1:0]  m_tdata
);
    import olist_pkg::*;

    logic                 r_valid;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [OUT_BITS-1:0]  r_out;
    logic [OUT_BITS-1:0]  n_out;
    logic                 accept;

    logic [CMD_W-1:0]     cmd;
    logic [VAL_W-1:0]     op_val;
    logic [POS_W-1:0]     op_pos;
    logic [POS_W-1:0]     pos_m1;
    logic [IDX_W-1:0]     pos_idx;
    logic                 pos_ok;
    logic                 full;
    logic                 empty;

    logic [VAL_W-1:0]     cell_data  [CAPACITY];
    t_cell_flags          cell_flags [CAPACITY];
    logic [VAL_W-1:0]     cell_left  [CAPACITY];
    logic [VAL_W-1:0]     cell_right [CAPACITY];
    t_cell_ctl            ctl;

    logic                 eq_hit;
    logic [IDX_W-1:0]     eq_idx;
    logic [IDX_W-1:0]     ge_idx;

    t_status              status;
    logic [CNT_W-1:0]     fpos;
    logic [VAL_W-1:0]     rval;
    logic                 do_ins;
    logic                 do_del;
    logic [IDX_W-1:0]     at;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !r_valid || m_tready;

    // Field unpacking
    assign cmd     = s_tdata[IN_CMD_LSB +: CMD_W];
    assign op_val  = s_tdata[IN_VAL_LSB +: VAL_W];
    assign op_pos  = s_tdata[IN_POS_LSB +: POS_W];
    assign pos_m1  = op_pos - POS_W'(1);
    assign pos_idx = pos_m1[IDX_W-1:0];
    assign pos_ok  = (op_pos != '0) && (CMP_W'(op_pos) <= CMP_W'(r_count));
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign empty   = (r_count == '0);

    // Cell chain; the ends see zero beyond the store
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        if (k == 0) begin : g_first
            assign cell_left[k] = '0;
        end else begin : g_mid_l
            assign cell_left[k] = cell_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign cell_right[k] = '0;
        end else begin : g_mid_r
            assign cell_right[k] = cell_data[k+1];
        end

        olist_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(k)),
            .i_ctl   (ctl),
            .i_left  (cell_left[k]),
            .i_right (cell_right[k]),
            .o_data  (cell_data[k]),
            .o_flags (cell_flags[k])
        );
    end

    // First occupied cell that matches the key, and first that is >= value
    always_comb begin
        eq_hit = 1'b0;
        eq_idx = '0;
        ge_idx = r_count[IDX_W-1:0];
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (CNT_W'(k) < r_count) begin
                if (cell_flags[k].eq) begin
                    eq_hit = 1'b1;
                    eq_idx = IDX_W'(k);
                end
                if (cell_flags[k].ge) begin
                    ge_idx = IDX_W'(k);
                end
            end
        end
    end

    // Command decode
    always_comb begin
        status  = ST_OK;
        fpos    = '0;
        rval    = '0;
        do_ins  = 1'b0;
        do_del  = 1'b0;
        at      = '0;
        n_count = r_count;
        case (t_cmd'(cmd))
            CMD_INS_FRONT, CMD_INS_REAR, CMD_INS_ORD: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (t_cmd'(cmd) == CMD_INS_REAR) begin
                        at = r_count[IDX_W-1:0];
                    end else if (t_cmd'(cmd) == CMD_INS_ORD) begin
                        at = ge_idx;
                    end
                end
            end
            CMD_SEARCH, CMD_DEL_KEY: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (!eq_hit) begin
                    status = ST_NOKEY;
                end else begin
                    fpos = CNT_W'(eq_idx) + CNT_W'(1);
                    if (t_cmd'(cmd) == CMD_DEL_KEY) begin
                        do_del  = 1'b1;
                        at      = eq_idx;
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            CMD_READ_POS, CMD_DEL_POS: begin
                if (!pos_ok) begin
                    status = ST_BADPOS;
                end else if (t_cmd'(cmd) == CMD_READ_POS) begin
                    rval = cell_data[pos_idx];
                end else begin
                    do_del  = 1'b1;
                    at      = pos_idx;
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_DEL_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    do_del  = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_DEL_REAR: begin
                // rear entry is simply dropped from the count
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Broadcast to the cells, only for a taken word
    always_comb begin
        ctl.ins   = accept && do_ins;
        ctl.del   = accept && do_del;
        ctl.at    = at;
        ctl.value = op_val;
    end

    always_comb begin
        n_out = {n_count, rval, fpos, status};
    end

    // Count and output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_count <= n_count;
            end else if (m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign m_tvalid = r_valid;
    assign m_tdata  = OUT_W'(r_out);

endmodule

FILE: sv/olist_checker.sv
// Port-level checks for the ordered list engine, bound to the top level.
// Depends on olist_pkg and ordered_list_engine_top.
module olist_port_checks (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [olist_pkg::IN_W-1:0]   s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [olist_pkg::OUT_W-1:0]  m_tdata
);
    import olist_pkg::*;

    logic [ST_W-1:0]  st;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] fp;

    assign st  = m_tdata[OUT_ST_LSB +: ST_W];
    assign cnt = m_tdata[OUT_CNT_LSB +: CNT_W];
    assign fp  = m_tdata[OUT_FP_LSB +: CNT_W];

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // every taken command gives a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("taken command gave no result");

    // count never exceeds the store size
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> cnt <= CNT_W'(CAPACITY))
        else $error("element count beyond capacity");

    // a full report only with a full store
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && st == ST_FULL |-> cnt == CNT_W'(CAPACITY) && fp == '0)
        else $error("full status with spare room");

    // an empty report only with an empty store
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && st == ST_EMPTY |-> cnt == '0 && fp == '0)
        else $error("empty status with stored elements");

endmodule

bind ordered_list_engine_top olist_port_checks u_olist_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
